>>> rtl/sawlc_pkg.sv
// shared codes, widths and helpers for the set-associative write-back cache
// no dependencies
package sawlc_pkg;

   localparam int WORD_W = 32;
   localparam int LAT_W  = 16;
   localparam int CFG_W  = 8;
   localparam int SETNUM_W = 4;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_FLUSH = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [1:0] CSR_HIT   = 2'd0;
   localparam logic [1:0] CSR_MRD   = 2'd1;
   localparam logic [1:0] CSR_MWR   = 2'd2;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TAG_RD  = 4'd1;
   localparam logic [3:0] S_TAG_CMP = 4'd2;
   localparam logic [3:0] S_VICTIM  = 4'd3;
   localparam logic [3:0] S_WB_RD   = 4'd4;
   localparam logic [3:0] S_WB_WR   = 4'd5;
   localparam logic [3:0] S_FILL_RD = 4'd6;
   localparam logic [3:0] S_FILL_WR = 4'd7;
   localparam logic [3:0] S_ACC     = 4'd8;
   localparam logic [3:0] S_ACC_RD  = 4'd9;
   localparam logic [3:0] S_FL_CHK  = 4'd10;
   localparam logic [3:0] S_RESP    = 4'd11;

   typedef logic [LAT_W-1:0] lat_type;

   function automatic lat_type sat_add(lat_type a, logic [CFG_W-1:0] b);
      logic [LAT_W:0] sum;
      sum = {1'b0, a} + (LAT_W+1)'(b);
      sat_add = sum[LAT_W] ? {LAT_W{1'b1}} : sum[LAT_W-1:0];
   endfunction

endpackage

>>> rtl/set_assoc_writeback_lru_cache.sv
// set-associative write-back write-allocate cache with true lru and backing memory
// depends on sawlc_pkg and sawlc_lru
//
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tuser: action; tdata: byte_address, write_word
// rsp      out  rsp_tvalid/tready    tdata: set_number, was_hit, latency_sum, read_word
// csr      in   csr_we               csr_index, csr_wdata
//
// one transaction at a time; req_tready is high only while idle
// lookup walks the ways through the tag memory port: a tag read and a compare per way probed
// a hit then goes through S_ACC, plus S_ACC_RD for a read, and on to the response state S_RESP
// a miss adds the victim state, a read and a write state per block word for a dirty write-back, and per word of fill
// flush visits every line in S_FL_CHK; a dirty line is written back word by word and then revisited
// reset is synchronous; the backing memory reads as zero per block until written
// a response holds until rsp_tready
module set_assoc_writeback_lru_cache
   import sawlc_pkg::*;
#(
   parameter int ADDR_W       = 12,
   parameter int WORD_BYTES   = 4,
   parameter int BLOCK_WORDS  = 4,
   parameter int WAYS         = 4,
   parameter int SETS         = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] action
   input  logic [1:0]   req_tuser,
   // byte_address, write_word
   input  logic [((ADDR_W+WORD_W+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] set_number, [4] was_hit, [20:5] latency_sum, [52:21] read_word
   output logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int WORD_SHIFT = $clog2(WORD_BYTES);
   localparam int OFF_W      = $clog2(BLOCK_WORDS);
   localparam int OFF_BITS   = (OFF_W > 0) ? OFF_W : 1;
   localparam int WADDR_BITS = ADDR_W - WORD_SHIFT;
   localparam int BLK_BITS   = WADDR_BITS - OFF_W;
   localparam int MEM_BLOCKS = 1 << BLK_BITS;
   localparam int MEM_DEPTH  = MEM_BLOCKS * BLOCK_WORDS;
   localparam int LINES      = SETS * WAYS;
   localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINE_BITS  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int DATA_DEPTH = LINES * BLOCK_WORDS;
   localparam int DATA_BITS  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

   logic [CFG_W-1:0] hit_cyc_ff, mrd_cyc_ff, mwr_cyc_ff;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            act_ff;
   logic [BLK_BITS-1:0]   blk_ff;
   logic [OFF_BITS-1:0]   off_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic [WORD_W-1:0]     wdata_ff;
   logic [WAY_BITS-1:0]   way_ff, way_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [OFF_BITS-1:0]   wc_ff, wc_in;
   lat_type               lat_ff, lat_in;
   logic                  hit_ff, hit_in;
   logic [WORD_W-1:0]     rword_ff, rword_in;
   logic [LINES-1:0]      valid_ff, valid_in, dirty_ff, dirty_in;

   logic [WORD_W-1:0]     data_mem [DATA_DEPTH];
   logic [BLK_BITS-1:0]   tag_mem [LINES];
   logic [WORD_W-1:0]     back_mem [MEM_DEPTH];
   logic [MEM_BLOCKS-1:0] bvalid_ff;

   logic [WORD_W-1:0]     data_rd_ff, mem_rd_ff;
   logic                  mem_ok_ff;
   logic [BLK_BITS-1:0]   tag_rd_ff;

   logic                  data_we, mem_we, tag_we, lru_en;
   logic [DATA_BITS-1:0]  data_raddr, data_waddr;
   logic [WORD_W-1:0]     data_wdata;
   logic [WADDR_BITS-1:0] mem_raddr, mem_waddr;
   logic [WAY_BITS-1:0]   victim;

   logic [ADDR_W-1:0]       req_addr;
   logic [WADDR_BITS-1:0]   req_word;
   logic [BLK_BITS-1:0]     req_blk;
   logic                    last_word, zero_fill, tag_match;

   assign req_addr  = req_tdata[ADDR_W-1:0];
   assign req_word  = req_addr[ADDR_W-1:WORD_SHIFT];
   assign req_blk   = BLK_BITS'(req_word / BLOCK_WORDS);
   assign last_word = (wc_ff == OFF_BITS'(BLOCK_WORDS - 1));
   assign zero_fill = (act_ff == ACT_WRITE) && (BLOCK_WORDS == 1);
   assign tag_match = valid_ff[line_ff] && (tag_rd_ff == blk_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cyc_ff <= CFG_W'(1);
         mrd_cyc_ff <= CFG_W'(2);
         mwr_cyc_ff <= CFG_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_HIT: hit_cyc_ff <= csr_wdata;
            CSR_MRD: mrd_cyc_ff <= csr_wdata;
            CSR_MWR: mwr_cyc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sawlc_lru #(
      .WAYS(WAYS), .SETS(SETS), .SET_BITS(SET_BITS), .WAY_BITS(WAY_BITS)
   ) u_lru (
      .clock(clock), .reset(reset),
      .upd_en(lru_en), .upd_set(set_ff), .upd_way(way_ff),
      .rd_set(set_ff), .victim(victim)
   );

   always_comb begin
      state_in  = state_ff;
      way_in    = way_ff;
      line_in   = line_ff;
      wc_in     = wc_ff;
      lat_in    = lat_ff;
      hit_in    = hit_ff;
      rword_in  = rword_ff;
      valid_in  = valid_ff;
      dirty_in  = dirty_ff;
      data_we   = 1'b0;
      mem_we    = 1'b0;
      tag_we    = 1'b0;
      lru_en    = 1'b0;
      data_wdata = wdata_ff;
      data_waddr = DATA_BITS'(int'(line_ff) * BLOCK_WORDS + int'(wc_ff));
      data_raddr = DATA_BITS'(int'(line_ff) * BLOCK_WORDS + int'(wc_ff));
      mem_raddr  = WADDR_BITS'(int'(blk_ff) * BLOCK_WORDS + int'(wc_ff));
      mem_waddr  = WADDR_BITS'(int'(tag_rd_ff) * BLOCK_WORDS + int'(wc_ff));
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               lat_in   = '0;
               hit_in   = 1'b0;
               rword_in = '0;
               way_in   = '0;
               wc_in    = '0;
               case (req_tuser)
                  ACT_READ, ACT_WRITE: begin
                     line_in  = LINE_BITS'(int'(req_blk % SETS) * WAYS);
                     state_in = S_TAG_RD;
                  end
                  ACT_FLUSH: begin
                     line_in  = '0;
                     state_in = S_FL_CHK;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_TAG_RD: state_in = S_TAG_CMP;
         S_TAG_CMP: begin
            if (tag_match) begin
               hit_in   = 1'b1;
               state_in = S_ACC;
            end else if (way_ff == WAY_BITS'(WAYS - 1)) begin
               way_in   = victim;
               line_in  = LINE_BITS'(int'(set_ff) * WAYS + int'(victim));
               state_in = S_VICTIM;
            end else begin
               way_in   = way_ff + 1'b1;
               line_in  = line_ff + 1'b1;
               state_in = S_TAG_RD;
            end
         end
         S_VICTIM: begin
            wc_in = '0;
            if (dirty_ff[line_ff]) begin
               state_in = S_WB_RD;
            end else begin
               state_in = zero_fill ? S_FILL_WR : S_FILL_RD;
            end
         end
         S_WB_RD: state_in = S_WB_WR;
         S_WB_WR: begin
            mem_we = 1'b1;
            wc_in  = wc_ff + 1'b1;
            state_in = S_WB_RD;
            if (last_word) begin
               wc_in = '0;
               dirty_in[line_ff] = 1'b0;
               lat_in = sat_add(lat_ff, mwr_cyc_ff);
               if (act_ff == ACT_FLUSH) begin
                  state_in = S_FL_CHK;
               end else begin
                  state_in = zero_fill ? S_FILL_WR : S_FILL_RD;
               end
            end
         end
         S_FILL_RD: state_in = S_FILL_WR;
         S_FILL_WR: begin
            data_we    = 1'b1;
            data_wdata = (mem_ok_ff && !zero_fill) ? mem_rd_ff : '0;
            wc_in      = wc_ff + 1'b1;
            state_in   = S_FILL_RD;
            if (last_word) begin
               wc_in  = '0;
               tag_we = 1'b1;
               valid_in[line_ff] = 1'b1;
               dirty_in[line_ff] = 1'b0;
               if (!zero_fill) begin
                  lat_in = sat_add(lat_ff, mrd_cyc_ff);
               end
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            lat_in     = sat_add(lat_ff, hit_cyc_ff);
            lru_en     = 1'b1;
            data_raddr = DATA_BITS'(int'(line_ff) * BLOCK_WORDS + int'(off_ff));
            data_waddr = data_raddr;
            if (act_ff == ACT_WRITE) begin
               data_we    = 1'b1;
               data_wdata = wdata_ff;
               dirty_in[line_ff] = 1'b1;
               state_in   = S_RESP;
            end else begin
               state_in   = S_ACC_RD;
            end
         end
         S_ACC_RD: begin
            rword_in = data_rd_ff;
            state_in = S_RESP;
         end
         S_FL_CHK: begin
            wc_in = '0;
            if (dirty_ff[line_ff]) begin
               state_in = S_WB_RD;
            end else if (line_ff == LINE_BITS'(LINES - 1)) begin
               state_in = S_RESP;
            end else begin
               line_in = line_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         dirty_ff  <= '0;
         bvalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         if (mem_we) begin
            bvalid_ff[tag_rd_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      way_ff   <= way_in;
      line_ff  <= line_in;
      wc_ff    <= wc_in;
      lat_ff   <= lat_in;
      hit_ff   <= hit_in;
      rword_ff <= rword_in;
      if (state_ff == S_IDLE && req_tvalid) begin
         act_ff   <= req_tuser;
         blk_ff   <= req_blk;
         off_ff   <= OFF_BITS'(req_word % BLOCK_WORDS);
         set_ff   <= SET_BITS'(req_blk % SETS);
         wdata_ff <= req_tdata[ADDR_W +: WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      data_rd_ff <= data_mem[data_raddr];
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[line_ff] <= blk_ff;
      end
      tag_rd_ff <= tag_mem[line_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         back_mem[mem_waddr] <= data_rd_ff;
      end
      mem_rd_ff <= back_mem[mem_raddr];
      mem_ok_ff <= bvalid_ff[blk_ff];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {3'd0, rword_ff, lat_ff, hit_ff,
                        (act_ff inside {ACT_READ, ACT_WRITE}) ?
                        SETNUM_W'(set_ff) : SETNUM_W'(0)};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new transaction taken while busy");

   a_flush_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && act_ff == ACT_FLUSH |-> rsp_tdata[4:0] == 5'd0 && rword_ff == '0)
      else $error("flush response carries set, hit or data");

   a_wb_only: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> dirty_ff[line_ff])
      else $error("write-back of a clean line");

endmodule

>>> rtl/sawlc_lru.sv
// true lru order per set with move-to-most-recent update
// depends on sawlc_pkg
module sawlc_lru
   import sawlc_pkg::*;
#(
   parameter int WAYS     = 4,
   parameter int SETS     = 16,
   parameter int SET_BITS = 4,
   parameter int WAY_BITS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                upd_en,
   input  logic [SET_BITS-1:0] upd_set,
   input  logic [WAY_BITS-1:0] upd_way,
   input  logic [SET_BITS-1:0] rd_set,
   output logic [WAY_BITS-1:0] victim
);

   logic [WAY_BITS-1:0] order_ff [SETS][WAYS];
   logic [WAY_BITS-1:0] row_in [WAYS];
   logic [WAY_BITS-1:0] pos;
   logic                found;

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!found && order_ff[upd_set][i] == upd_way) begin
            found = 1'b1;
            pos   = WAY_BITS'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         if (!found || i < int'(pos)) begin
            row_in[i] = order_ff[upd_set][i];
         end else if (i == WAYS - 1) begin
            row_in[i] = upd_way;
         end else begin
            row_in[i] = order_ff[upd_set][(i + 1) % WAYS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               order_ff[s][w] <= WAY_BITS'(w);
            end
         end
      end else if (upd_en) begin
         order_ff[upd_set] <= row_in;
      end
   end

   assign victim = order_ff[rd_set][0];

endmodule
